FILE: rtl/dtf_pkg.sv
`timescale 1ns / 1ps

package dtf_pkg;

  // Widths of the request and result fields.
  localparam int OP_W     = 3;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 4;
  localparam int NUM_W    = 17;
  localparam int CODE_W   = 8;

  // Magnitude and BCD conversion geometry.
  localparam int MAG_W    = 16;
  localparam int DIGITS   = 5;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int STEP_W   = $clog2(MAG_W);
  localparam int POS_W    = 3;
  localparam int DIG_IX_W = 3;

  localparam int FIELD_WIDE = 6;

  // Display command bases for the four rows.
  localparam logic [CODE_W-1:0] ROW1_BASE = 8'h80;
  localparam logic [CODE_W-1:0] ROW2_BASE = 8'h90;
  localparam logic [CODE_W-1:0] ROW3_BASE = 8'h88;
  localparam logic [CODE_W-1:0] ROW4_BASE = 8'h98;

  localparam logic [CODE_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CODE_W-1:0] ASCII_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] ASCII_PLUS  = 8'h2B;
  localparam logic [CODE_W-1:0] ASCII_MINUS = 8'h2D;

  localparam logic [MAG_W-1:0] SIGNED_MAX = 16'd32767;
  localparam logic [MAG_W-1:0] SHORT_MAX  = 16'd999;

  // Formatting modes, equal to the request op codes.
  typedef enum logic [OP_W-1:0] {
    MODE_PLAIN   = 3'd0,
    MODE_RIGHT   = 3'd1,
    MODE_LEFT    = 3'd2,
    MODE_SIGNED5 = 3'd3,
    MODE_SIGNED3 = 3'd4
  } fmt_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } back_state_t;

  // A classified request as it travels from the front to the back.
  typedef struct packed {
    fmt_mode_t          mode;
    logic               has_addr;
    logic [CODE_W-1:0]  addr_code;
    logic               neg;
    logic [MAG_W-1:0]   mag;
  } fe_req_t;

endpackage

FILE: rtl/dtf_if.sv
`timescale 1ns / 1ps

interface dtf_in_if import dtf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [ROW_W-1:0]        row;
  logic [COL_W-1:0]        col;
  logic signed [NUM_W-1:0] number;

  modport source (output valid, op, row, col, number, input ready);
  modport sink   (input valid, op, row, col, number, output ready);
endinterface

interface dtf_out_if import dtf_pkg::*;;
  logic              valid;
  logic              ready;
  logic              is_data;
  logic [CODE_W-1:0] code;
  logic              last;

  modport source (output valid, is_data, code, last, input ready);
  modport sink   (input valid, is_data, code, last, output ready);
endinterface

FILE: rtl/decimal_text_formatter_core.sv
`timescale 1ns / 1ps

// Formats one number per request into a run of character-display bytes, each
// tagged as a command or character data, with the final byte flagged. A front
// stage classifies each request (mode, address command, clamped magnitude)
// and drops unknown modes; a small queue of QUEUE_DEPTH entries decouples it
// from the back stage, so new requests are taken while earlier ones are still
// being printed. The back stage turns the magnitude into five BCD digits with
// a shift-and-add-3 loop over the 16 magnitude bits, one bit per cycle, then
// sends one byte per cycle through a registered output, stalling while the
// output is not ready.
module decimal_text_formatter_core import dtf_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  dtf_in_if.sink    in_ch,
  dtf_out_if.source out_ch
);

  // Classified requests between the front and the back.
  fe_req_t push_req;
  fe_req_t head_req;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;

  // The front accepts whenever the queue has room.
  dtf_front u_front (
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .in_row    (in_ch.row),
    .in_col    (in_ch.col),
    .in_number (in_ch.number),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_req     (push_req)
  );

  dtf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_req)
  );

  // The back converts and emits one request at a time.
  dtf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (!q_empty),
    .q_req       (head_req),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_is_data (out_ch.is_data),
    .out_code    (out_ch.code),
    .out_last    (out_ch.last)
  );

endmodule

FILE: rtl/dtf_front.sv
`timescale 1ns / 1ps

module dtf_front import dtf_pkg::*; (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_op,
  input  logic [ROW_W-1:0]        in_row,
  input  logic [COL_W-1:0]        in_col,
  input  logic signed [NUM_W-1:0] in_number,
  input  logic                    q_full,
  output logic                    q_push,
  output fe_req_t                 q_req
);

  logic                    op_ok;
  logic                    row_ok;
  logic [CODE_W-1:0]       row_base;
  logic signed [NUM_W-1:0] clamped;
  logic [NUM_W-1:0]        negated;
  logic [MAG_W-1:0]        smag;

  // Requests with an unknown mode are taken and dropped.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && op_ok;

  always_comb begin
    row_ok = 1'b1;
    unique case (in_row)
      3'd1:    row_base = ROW1_BASE;
      3'd2:    row_base = ROW2_BASE;
      3'd3:    row_base = ROW3_BASE;
      3'd4:    row_base = ROW4_BASE;
      default: begin
        row_base = ROW1_BASE;
        row_ok   = 1'b0;
      end
    endcase
  end

  // Signed path: saturate to the 16-bit signed range, then take the magnitude.
  always_comb begin
    if (in_number > $signed(NUM_W'(SIGNED_MAX))) begin
      clamped = $signed(NUM_W'(SIGNED_MAX));
    end else if (in_number < -$signed(NUM_W'(32768))) begin
      clamped = -$signed(NUM_W'(32768));
    end else begin
      clamped = in_number;
    end
    negated = NUM_W'(-clamped);
    smag    = in_number[NUM_W-1] ? negated[MAG_W-1:0] : clamped[MAG_W-1:0];
  end

  always_comb begin
    op_ok           = 1'b1;
    q_req.mode      = fmt_mode_t'(in_op);
    q_req.has_addr  = 1'b0;
    q_req.addr_code = row_base | CODE_W'(in_col - 1'b1);
    q_req.neg       = 1'b0;
    q_req.mag       = '0;
    unique case (in_op) inside
      MODE_PLAIN, MODE_RIGHT, MODE_LEFT: begin
        q_req.has_addr = row_ok && (in_col != '0);
        q_req.mag      = in_number[NUM_W-1] ? '0 : in_number[MAG_W-1:0];
      end
      MODE_SIGNED5: begin
        q_req.neg = in_number[NUM_W-1];
        q_req.mag = smag;
      end
      MODE_SIGNED3: begin
        q_req.neg = in_number[NUM_W-1];
        q_req.mag = (smag > SHORT_MAX) ? SHORT_MAX : smag;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/dtf_queue.sv
`timescale 1ns / 1ps

module dtf_queue import dtf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  fe_req_t push_req,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output fe_req_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fe_req_t            entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_req;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("request written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("request taken from an empty queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue fill count lost a write");

endmodule

FILE: rtl/dtf_back.sv
`timescale 1ns / 1ps

module dtf_back import dtf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  fe_req_t           q_req,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_data,
  output logic [CODE_W-1:0] out_code,
  output logic              out_last
);

  back_state_t        state_r, state_nxt;
  fmt_mode_t          mode_r, mode_nxt;
  logic               has_addr_r, has_addr_nxt;
  logic [CODE_W-1:0]  addr_code_r, addr_code_nxt;
  logic               neg_r, neg_nxt;
  logic [MAG_W-1:0]   bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_is_data_r, out_is_data_nxt;
  logic [CODE_W-1:0]  out_code_r, out_code_nxt;
  logic               out_last_r, out_last_nxt;

  logic [BCD_W-1:0]    bcd_adj;
  logic [DIG_IX_W-1:0] lz;
  logic [DIG_IX_W-1:0] n_dig;
  logic [POS_W-1:0]    total;
  logic [POS_W-1:0]    j;
  logic                load;
  logic                byte_data;
  logic [CODE_W-1:0]   byte_code;
  logic                byte_last;
  logic [CODE_W-1:0]   sign_char;

  function automatic logic [CODE_W-1:0] digit_char(input logic [BCD_W-1:0] bcd,
                                                   input logic [DIG_IX_W-1:0] ix);
    logic [3:0] d;
    case (ix)
      3'd0:    d = bcd[19:16];
      3'd1:    d = bcd[15:12];
      3'd2:    d = bcd[11:8];
      3'd3:    d = bcd[7:4];
      default: d = bcd[3:0];
    endcase
    return ASCII_ZERO | CODE_W'(d);
  endfunction

  // Double-dabble correction: any digit of five or more gets three added.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                     : bcd_r[4*i +: 4];
    end
  end

  // Leading zero digits, capped so that at least one digit is printed.
  always_comb begin
    if (bcd_r[19:16] != 4'd0) begin
      lz = 3'd0;
    end else if (bcd_r[15:12] != 4'd0) begin
      lz = 3'd1;
    end else if (bcd_r[11:8] != 4'd0) begin
      lz = 3'd2;
    end else if (bcd_r[7:4] != 4'd0) begin
      lz = 3'd3;
    end else begin
      lz = 3'd4;
    end
    n_dig = DIG_IX_W'(DIGITS) - lz;
  end

  assign sign_char = neg_r ? ASCII_MINUS : ASCII_PLUS;
  assign j         = pos_r - POS_W'(has_addr_r);

  // Byte at the current position of the run.
  always_comb begin
    unique case (mode_r)
      MODE_PLAIN:   total = POS_W'(has_addr_r) + POS_W'(n_dig);
      MODE_RIGHT,
      MODE_LEFT:    total = POS_W'(has_addr_r) + POS_W'(FIELD_WIDE);
      MODE_SIGNED5: total = POS_W'(FIELD_WIDE + 1);
      default:      total = POS_W'(4);
    endcase

    byte_data = 1'b1;
    byte_code = ASCII_SPACE;
    if (has_addr_r && pos_r == '0) begin
      byte_data = 1'b0;
      byte_code = addr_code_r;
    end else begin
      unique case (mode_r)
        MODE_PLAIN: begin
          byte_code = digit_char(bcd_r, lz + j);
        end
        MODE_RIGHT: begin
          if (j != '0 && (j - 1'b1) >= lz) begin
            byte_code = digit_char(bcd_r, j - 1'b1);
          end
        end
        MODE_LEFT: begin
          if (j < n_dig) begin
            byte_code = digit_char(bcd_r, lz + j);
          end
        end
        MODE_SIGNED5: begin
          if (j == '0) begin
            byte_code = sign_char;
          end else if (j != POS_W'(FIELD_WIDE)) begin
            byte_code = digit_char(bcd_r, j - 1'b1);
          end
        end
        default: begin
          if (j == '0) begin
            byte_code = sign_char;
          end else begin
            byte_code = digit_char(bcd_r, j + 1'b1);
          end
        end
      endcase
    end
    byte_last = (pos_r == total - 1'b1);
  end

  assign load = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    has_addr_nxt    = has_addr_r;
    addr_code_nxt   = addr_code_r;
    neg_nxt         = neg_r;
    bin_nxt         = bin_r;
    bcd_nxt         = bcd_r;
    step_nxt        = step_r;
    pos_nxt         = pos_r;
    q_pop           = 1'b0;
    out_valid_nxt   = out_ready ? 1'b0 : out_valid_r;
    out_is_data_nxt = out_is_data_r;
    out_code_nxt    = out_code_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          mode_nxt      = q_req.mode;
          has_addr_nxt  = q_req.has_addr;
          addr_code_nxt = q_req.addr_code;
          neg_nxt       = q_req.neg;
          bin_nxt       = q_req.mag;
          bcd_nxt       = '0;
          step_nxt      = '0;
          pos_nxt       = '0;
          state_nxt     = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt  = {bcd_adj[BCD_W-2:0], bin_r[MAG_W-1]};
        bin_nxt  = {bin_r[MAG_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(MAG_W - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt   = 1'b1;
          out_is_data_nxt = byte_data;
          out_code_nxt    = byte_code;
          out_last_nxt    = byte_last;
          pos_nxt         = pos_r + 1'b1;
          if (byte_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    has_addr_r    <= has_addr_nxt;
    addr_code_r   <= addr_code_nxt;
    neg_r         <= neg_nxt;
    bin_r         <= bin_nxt;
    bcd_r         <= bcd_nxt;
    step_r        <= step_nxt;
    pos_r         <= pos_nxt;
    out_is_data_r <= out_is_data_nxt;
    out_code_r    <= out_code_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_is_data = out_is_data_r;
  assign out_code    = out_code_r;
  assign out_last    = out_last_r;

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> (bcd_r[19:16] <= 4'd9) && (bcd_r[15:12] <= 4'd9) &&
                           (bcd_r[11:8] <= 4'd9) && (bcd_r[7:4] <= 4'd9) &&
                           (bcd_r[3:0] <= 4'd9))
    else $error("conversion left a digit above nine");

  a_pos_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> pos_r < total)
    else $error("byte position ran past the end of the run");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (load && byte_last) |=> state_r == ST_IDLE && out_valid && out_last)
    else $error("final byte did not close the request");

endmodule
